/* design/abs_pkg.sv */
`default_nettype none

package abs_pkg;

    // Field widths fixed by the stream and register formats
    localparam int SAMPLE_W  = 24;
    localparam int CFG_W     = 16;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int AGL_EXT_W = 26;

    // Capture phase codes
    localparam logic [1:0] PHASE_CAPTURE   = 2'd0;
    localparam logic [1:0] PHASE_SETTLED   = 2'd1;
    localparam logic [1:0] PHASE_TIMED_OUT = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRIM      = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd300;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd39;
    localparam logic [CFG_W-1:0] TRIM_RST      = 16'd0;

    // Saturation limits of the reported altitude
    localparam logic [SAMPLE_W-1:0] AGL_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] AGL_MIN = 24'h80_0000;

    typedef struct packed {
        logic [CFG_W-1:0] timeout;
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] trim;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic div_step;
        logic mean;
        logic decide;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* design/abs_cfg.sv */
`default_nettype none

module abs_cfg
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [abs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [abs_pkg::APB_W-1:0]   pwdata,
    output logic      [abs_pkg::APB_W-1:0]   prdata,
    output logic                             pready,
    output abs_pkg::cfg_t                    cfg
);

    abs_pkg::cfg_t                    cfg_reg;
    logic [abs_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[abs_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout   <= abs_pkg::TIMEOUT_RST;
            cfg_reg.threshold <= abs_pkg::THRESHOLD_RST;
            cfg_reg.trim      <= abs_pkg::TRIM_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                abs_pkg::REG_TIMEOUT:   cfg_reg.timeout   <= pwdata[abs_pkg::CFG_W-1:0];
                abs_pkg::REG_THRESHOLD: cfg_reg.threshold <= pwdata[abs_pkg::CFG_W-1:0];
                abs_pkg::REG_TRIM:      cfg_reg.trim      <= pwdata[abs_pkg::CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back, trim sign-extended
    always_comb
    begin
        unique case (reg_idx)
            abs_pkg::REG_TIMEOUT:
                prdata = {{(abs_pkg::APB_W-abs_pkg::CFG_W){1'b0}}, cfg_reg.timeout};
            abs_pkg::REG_THRESHOLD:
                prdata = {{(abs_pkg::APB_W-abs_pkg::CFG_W){1'b0}}, cfg_reg.threshold};
            abs_pkg::REG_TRIM:
                prdata = {{(abs_pkg::APB_W-abs_pkg::CFG_W){cfg_reg.trim[abs_pkg::CFG_W-1]}},
                          cfg_reg.trim};
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* design/abs_ctrl.sv */
`default_nettype none

module abs_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire abs_pkg::dp_status_t status,
    output abs_pkg::ctrl_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MEAN   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one item: load, evaluate window, divide, average and decide if needed, emit
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                cmd.mean   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/abs_datapath.sv */
`default_nettype none

module abs_datapath #(
    parameter int WINDOW_SLOTS = 10
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire abs_pkg::ctrl_cmd_t            cmd,
    output abs_pkg::dp_status_t                status,
    input  wire abs_pkg::cfg_t                 cfg,
    input  wire logic                          in_ok,
    input  wire logic [abs_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [abs_pkg::SAMPLE_W-1:0]       out_agl,
    output logic [3:0]                         out_flags
);

    localparam int CNT_W     = $clog2(WINDOW_SLOTS + 1);
    localparam int SUM_W     = abs_pkg::SAMPLE_W + CNT_W;
    localparam int STEP_W    = $clog2(SUM_W);
    localparam int SW        = abs_pkg::SAMPLE_W;
    localparam int EW        = abs_pkg::AGL_EXT_W;

    // Item registers
    logic                  ok_reg;
    logic [SW-1:0]         sample_reg;

    // Capture state
    logic [1:0]            phase_reg;
    logic [15:0]           elapsed_reg;
    logic [CNT_W-1:0]      slots_reg;
    logic [CNT_W-1:0]      vcount_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SW-1:0]         prev_mean_reg;
    logic                  prev_valid_reg;
    logic [SW-1:0]         baseline_reg;

    // Per-item flags
    logic                  cap_reg;
    logic                  close_reg;
    logic                  tout_reg;

    // Divider
    logic [CNT_W-1:0]      rem_reg;
    logic [SUM_W-1:0]      dvd_reg;
    logic                  neg_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SW-1:0]         mean_reg;

    // Result register
    logic                  out_valid_reg;
    logic [SW-1:0]         out_agl_reg;
    logic [3:0]            out_flags_reg;

    logic [SUM_W-1:0]      sample_ext;
    logic [15:0]           elapsed_inc;
    logic                  timed_out;
    logic                  win_full;
    logic                  close;
    logic [SUM_W-1:0]      sum_mag;
    logic [CNT_W:0]        rem_sh;
    logic [CNT_W:0]        rem_diff;
    logic                  q_bit;
    logic [SUM_W-1:0]      quot_signed;
    logic [SW:0]           mean_diff;
    logic [SW:0]           mean_mag;
    logic                  settled;
    logic [EW-1:0]         agl_wide;
    logic [SW-1:0]         agl_sat;
    logic                  agl_valid;
    logic                  go_timeout;
    logic [1:0]            phase_next;
    logic [SW-1:0]         baseline_next;

    assign sample_ext  = {{(SUM_W-SW){in_sample[SW-1]}}, in_sample};
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    // Window close test on the updated counters
    assign timed_out = (elapsed_reg >= cfg.timeout);
    assign win_full  = (slots_reg >= CNT_W'(WINDOW_SLOTS));
    assign close     = (phase_reg == abs_pkg::PHASE_CAPTURE) && (win_full || timed_out);

    // Divider step: restoring, one quotient bit a cycle
    assign sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, vcount_reg};
    assign q_bit    = (rem_sh >= {1'b0, vcount_reg});
    assign quot_signed = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;

    // Settle test on the new mean
    assign mean_diff = {mean_reg[SW-1], mean_reg} - {prev_mean_reg[SW-1], prev_mean_reg};
    assign mean_mag  = mean_diff[SW] ? (~mean_diff + 1'b1) : mean_diff;
    assign settled   = prev_valid_reg
                       && (mean_mag < {{(SW+1-abs_pkg::CFG_W){1'b0}}, cfg.threshold});

    // Launch-relative altitude, clamped to 24 bits
    assign agl_wide = {{(EW-SW){sample_reg[SW-1]}}, sample_reg}
                    - {{(EW-SW){baseline_reg[SW-1]}}, baseline_reg}
                    + {{(EW-abs_pkg::CFG_W){cfg.trim[abs_pkg::CFG_W-1]}}, cfg.trim};

    always_comb
    begin
        if (agl_wide[EW-1:SW-1] == '0 || agl_wide[EW-1:SW-1] == '1)
        begin
            agl_sat = agl_wide[SW-1:0];
        end
        else if (agl_wide[EW-1])
        begin
            agl_sat = abs_pkg::AGL_MIN;
        end
        else
        begin
            agl_sat = abs_pkg::AGL_MAX;
        end
    end

    assign agl_valid  = !cap_reg && ok_reg;
    assign go_timeout = cap_reg && close_reg && tout_reg
                        && (phase_reg == abs_pkg::PHASE_CAPTURE);

    always_comb
    begin
        phase_next    = phase_reg;
        baseline_next = baseline_reg;
        if (go_timeout)
        begin
            phase_next    = abs_pkg::PHASE_TIMED_OUT;
            baseline_next = prev_valid_reg ? prev_mean_reg : '0;
        end
    end

    assign status.need_div = close && (vcount_reg != '0);
    assign status.div_last = (step_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    // Latch the item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg     <= in_ok;
            sample_reg <= in_sample;
        end
    end

    // Capture state and per-item flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= abs_pkg::PHASE_CAPTURE;
            elapsed_reg    <= '0;
            slots_reg      <= '0;
            vcount_reg     <= '0;
            sum_reg        <= '0;
            prev_mean_reg  <= '0;
            prev_valid_reg <= 1'b0;
            baseline_reg   <= '0;
            cap_reg        <= 1'b0;
            close_reg      <= 1'b0;
            tout_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cap_reg <= (phase_reg == abs_pkg::PHASE_CAPTURE);
                if (phase_reg == abs_pkg::PHASE_CAPTURE)
                begin
                    elapsed_reg <= elapsed_inc;
                    slots_reg   <= slots_reg + 1'b1;
                    if (in_ok)
                    begin
                        sum_reg    <= sum_reg + sample_ext;
                        vcount_reg <= vcount_reg + 1'b1;
                    end
                end
            end
            if (cmd.eval)
            begin
                close_reg <= close;
                tout_reg  <= timed_out;
            end
            if (cmd.decide)
            begin
                if (settled)
                begin
                    baseline_reg <= mean_reg;
                    phase_reg    <= abs_pkg::PHASE_SETTLED;
                end
                else
                begin
                    prev_mean_reg  <= mean_reg;
                    prev_valid_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                phase_reg    <= phase_next;
                baseline_reg <= baseline_next;
                if (close_reg)
                begin
                    slots_reg  <= '0;
                    vcount_reg <= '0;
                    sum_reg    <= '0;
                end
            end
        end
    end

    // Divide the window sum by the valid count
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg  <= sum_reg[SUM_W-1];
            dvd_reg  <= sum_mag;
            rem_reg  <= '0;
            step_reg <= STEP_W'(SUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            dvd_reg  <= {dvd_reg[SUM_W-2:0], q_bit};
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.mean)
        begin
            mean_reg <= quot_signed[SW-1:0];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_agl_reg   <= agl_valid ? agl_sat : '0;
            out_flags_reg <= {close_reg, agl_valid, phase_next};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_agl   = out_agl_reg;
    assign out_flags = out_flags_reg;

endmodule

`default_nettype wire

/* design/altitude_baseline_settle_unit.sv */
// Sequence: a slot with no window mean passes through evaluate and finish; when a window closes
// with valid samples the restoring divider (one bit a cycle) runs first, then the mean and
// decide states.
// Throughput: one item in flight; the next item is taken only after the result is registered,
// and the finish state waits while the previous result is held by an output stall.
// Reset: rst_n clears capture state, flags and result valid; registers reload 300, 39, 0.
`default_nettype none

module altitude_baseline_settle_unit #(
    parameter int WINDOW_SLOTS = 10
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,   // [23:0] altitude_sample
    input  wire logic                         s_tuser,   // [0] reading_ok
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [23:0]                       m_tdata,   // [23:0] altitude_agl
    output logic [3:0]                        m_tuser,   // [1:0] phase, [2] agl_valid,
                                                         // [3] window_closed
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [abs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [abs_pkg::APB_W-1:0]    pwdata,
    output logic      [abs_pkg::APB_W-1:0]    prdata,
    output logic                              pready
);

    abs_pkg::cfg_t       cfg;
    abs_pkg::ctrl_cmd_t  cmd;
    abs_pkg::dp_status_t status;

    abs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    abs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    abs_datapath #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .in_ok     (s_tuser),
        .in_sample (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_agl   (m_tdata),
        .out_flags (m_tuser)
    );

endmodule

`default_nettype wire

/* design/abs_checker.sv */
`default_nettype none

module abs_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One item at a time: input closes after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // No altitude reading means a zero altitude field
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tdata == 24'd0)
        else $error("altitude set without agl_valid");

    // Altitude readings only after the capture has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] != abs_pkg::PHASE_CAPTURE && !m_tuser[3])
        else $error("altitude reported during capture");

    // Phase code is always one of the known phases
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[1:0] == abs_pkg::PHASE_CAPTURE
                     || m_tuser[1:0] == abs_pkg::PHASE_SETTLED
                     || m_tuser[1:0] == abs_pkg::PHASE_TIMED_OUT)
        else $error("bad phase code");

endmodule

bind altitude_baseline_settle_unit abs_checker u_abs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/altitude_baseline_settle_unit_test.sv */
`timescale 1ns / 1ps

module altitude_baseline_settle_unit_test;
    import abs_pkg::*;

    // Signed limits of a 24-bit sample
    localparam longint SAMPLE_TOP    = 64'sd8388607;
    localparam longint SAMPLE_BOTTOM = -64'sd8388608;
    // Register slot past the last one, writes there must be ignored
    localparam int UNMAPPED_REG = 3;
    // Cycles with no handshake before the run is abandoned
    localparam int QUIET_LIMIT = 4000;
    // Cycles to leave after the last result before a register write or the end
    localparam int LATENCY_PAD = 48;

    // Kinds of capture window content
    localparam int WIN_EMPTY = 0;
    localparam int WIN_WIDE  = 1;
    localparam int WIN_MIXED = 2;
    localparam int WIN_LEVEL = 3;
    localparam int WIN_TRACK = 4;

    // How the capture is brought to an end
    localparam int END_SETTLE       = 0;
    localparam int END_TIMEOUT_CUT  = 1;
    localparam int END_TIMEOUT_ZERO = 2;

    typedef struct packed {
        logic [1:0]  phase;
        logic        agl_valid;
        logic [23:0] agl;
        logic        closed;
    } settle_result_t;

    // Mirror of the baseline capture, with the queue of outstanding results
    class settle_scoreboard;
        localparam int SLOTS_PER_WINDOW = 10;

        int cfg_timeout;
        int cfg_threshold;
        int cfg_trim;

        logic [1:0] phase_now;
        int         elapsed;
        int         slots_win;
        int         valid_win;
        longint     win_sum;
        longint     prev_mean;
        bit         prev_valid;
        longint     base;

        settle_result_t expected_q[$];
        int             errors;

        function new();
            cfg_timeout   = int'(TIMEOUT_RST);
            cfg_threshold = int'(THRESHOLD_RST);
            cfg_trim      = int'($signed(TRIM_RST));
            phase_now     = PHASE_CAPTURE;
            elapsed       = 0;
            slots_win     = 0;
            valid_win     = 0;
            win_sum       = 0;
            prev_mean     = 0;
            prev_valid    = 1'b0;
            base          = 0;
            errors        = 0;
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void write_reg(int idx, logic [31:0] val);
            if (idx == REG_TIMEOUT)
                cfg_timeout = int'(val[15:0]);
            else if (idx == REG_THRESHOLD)
                cfg_threshold = int'(val[15:0]);
            else if (idx == REG_TRIM)
                cfg_trim = int'($signed(val[15:0]));
        endfunction

        function logic [15:0] reg_value(int idx);
            if (idx == REG_TIMEOUT)
                return cfg_timeout[15:0];
            else if (idx == REG_THRESHOLD)
                return cfg_threshold[15:0];
            return cfg_trim[15:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit capturing();
            return phase_now == PHASE_CAPTURE;
        endfunction

        // Advance one slot and queue the result it produces
        function void note_sample(logic ok, logic [23:0] sample);
            settle_result_t r;
            int     s;
            bit     timed_out;
            longint mean;
            longint d;
            longint agl;
            s = int'($signed(sample));
            r = '0;
            if (phase_now == PHASE_CAPTURE) begin
                if (elapsed < 65535)
                    elapsed++;
                slots_win++;
                if (ok) begin
                    win_sum += s;
                    valid_win++;
                end
                timed_out = elapsed >= cfg_timeout;
                if (slots_win >= SLOTS_PER_WINDOW || timed_out) begin
                    r.closed = 1'b1;
                    if (valid_win != 0) begin
                        mean = win_sum / valid_win;
                        d = mean - prev_mean;
                        if (d < 0)
                            d = -d;
                        if (prev_valid && d < cfg_threshold) begin
                            base = mean;
                            phase_now = PHASE_SETTLED;
                        end
                        else begin
                            prev_mean = mean;
                            prev_valid = 1'b1;
                        end
                    end
                    slots_win = 0;
                    valid_win = 0;
                    win_sum = 0;
                    if (phase_now == PHASE_CAPTURE && timed_out) begin
                        base = prev_valid ? prev_mean : 0;
                        phase_now = PHASE_TIMED_OUT;
                    end
                end
            end
            else if (ok) begin
                agl = s - base + cfg_trim;
                if (agl > SAMPLE_TOP)
                    agl = SAMPLE_TOP;
                if (agl < SAMPLE_BOTTOM)
                    agl = SAMPLE_BOTTOM;
                r.agl_valid = 1'b1;
                r.agl = agl[23:0];
            end
            r.phase = phase_now;
            expected_q.push_back(r);
        endfunction

        // Compare one delivered result with the oldest outstanding one
        task check_result(logic [23:0] data, logic [3:0] user);
            settle_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with none outstanding: data %h user %h", data, user));
                return;
            end
            want = expected_q.pop_front();
            if (user[1:0] !== want.phase)
                report($sformatf("phase %0d, wanted %0d", user[1:0], want.phase));
            if (user[2] !== want.agl_valid)
                report($sformatf("agl_valid %b, wanted %b", user[2], want.agl_valid));
            if (data !== want.agl)
                report($sformatf("altitude_agl %h, wanted %h", data, want.agl));
            if (user[3] !== want.closed)
                report($sformatf("window_closed %b, wanted %b", user[3], want.closed));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // [23:0] altitude_sample
    logic              s_tuser;   // [0] reading_ok
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;   // [23:0] altitude_agl
    logic [3:0]        m_tuser;   // [1:0] phase, [2] agl_valid, [3] window_closed
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    settle_scoreboard sb;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               quiet_cycles;

    altitude_baseline_settle_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Stall the result side at random
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Record accepted items, check results, watch for a hang
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("altitude_baseline_settle_unit_test: FAIL");
                $finish;
            end
        end
    end

    function automatic longint random_sample();
        logic [31:0] r;
        r = $urandom;
        return $signed(r[23:0]);
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        else if (v < SAMPLE_BOTTOM)
            v = SAMPLE_BOTTOM;
        return v[23:0];
    endfunction

    function automatic longint jitter(longint level, int spread);
        int off;
        off = $urandom_range(0, 2 * spread);
        off -= spread;
        return level + off;
    endfunction

    // Offer one item, with a random gap first; returns on the falling edge after acceptance
    task automatic send_sample(input logic ok, input logic [23:0] sample);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= ok;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result has been delivered
    task automatic hold_until_drained(input int pad_cycles);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (pad_cycles) @(negedge clk);
    endtask

    task automatic program_reg(input int idx, input logic [31:0] val);
        sb.write_reg(idx, val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_reg(input int idx);
        logic [15:0] want;
        want = sb.reg_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[15:0] !== want)
            sb.report($sformatf("register %0d reads %h, wanted %h", idx, prdata[15:0], want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // One capture window; stops early once the capture has ended
    task automatic send_window(input int kind, input longint level);
        int     n;
        logic   ok;
        longint v;
        n = 0;
        while (n < settle_scoreboard::SLOTS_PER_WINDOW && sb.capturing()) begin
            case (kind)
                WIN_EMPTY: begin
                    ok = 1'b0;
                    v = random_sample();
                end
                WIN_WIDE: begin
                    ok = 1'b1;
                    v = random_sample();
                end
                WIN_MIXED: begin
                    ok = ($urandom_range(0, 1) != 0);
                    v = random_sample();
                end
                WIN_LEVEL: begin
                    ok = ($urandom_range(0, 9) != 0);
                    v = jitter(level, 100);
                end
                default: begin
                    ok = ($urandom_range(0, 9) != 0);
                    v = jitter(sb.prev_mean, 1000);
                end
            endcase
            send_sample(ok, clamp24(v));
            n++;
        end
    endtask

    // One launch-relative item, leaning on the saturation edges now and then
    task automatic send_agl_item();
        int     pick;
        longint v;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            v = $urandom_range(0, 1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
        else if (pick < 14)
            v = jitter(SAMPLE_TOP + sb.base - sb.cfg_trim, 3);
        else if (pick < 20)
            v = jitter(SAMPLE_BOTTOM + sb.base - sb.cfg_trim, 3);
        else
            v = random_sample();
        send_sample($urandom_range(0, 99) < 85, clamp24(v));
    endtask

    initial begin
        int end_kind;
        int n_win;
        int trim_val;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet_cycles = 0;
        tx_idle_pct = 6;
        rx_idle_pct = 75;
        sb = new();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values, then a capture that cannot settle until told to
        check_reg(REG_TIMEOUT);
        check_reg(REG_THRESHOLD);
        check_reg(REG_TRIM);
        program_reg(REG_THRESHOLD, 32'd0);
        program_reg(REG_TIMEOUT, 32'h0000_FFFF);
        program_reg(REG_TRIM, $urandom);
        program_reg(UNMAPPED_REG, $urandom);
        check_reg(REG_TIMEOUT);
        check_reg(REG_THRESHOLD);
        check_reg(REG_TRIM);

        // Windows at both sample extremes
        repeat (settle_scoreboard::SLOTS_PER_WINDOW) send_sample(1'b1, SAMPLE_TOP[23:0]);
        repeat (settle_scoreboard::SLOTS_PER_WINDOW) send_sample(1'b1, SAMPLE_BOTTOM[23:0]);

        // Random windows while capturing
        n_win = $urandom_range(3, 8);
        repeat (n_win) send_window($urandom_range(WIN_EMPTY, WIN_LEVEL), random_sample());

        // End the capture one of three ways
        end_kind = $urandom_range(END_SETTLE, END_TIMEOUT_ZERO);
        hold_until_drained(LATENCY_PAD);
        case (end_kind)
            END_SETTLE: begin
                program_reg(REG_THRESHOLD, 32'h0000_FFFF);
                while (sb.capturing())
                    send_window(WIN_TRACK, 0);
            end
            END_TIMEOUT_CUT: begin
                program_reg(REG_TIMEOUT, sb.elapsed + $urandom_range(1, 9));
                while (sb.capturing())
                    send_window($urandom_range(WIN_EMPTY, WIN_LEVEL), random_sample());
            end
            default: begin
                program_reg(REG_TIMEOUT, 32'd0);
                send_window(WIN_WIDE, 0);
            end
        endcase

        // Launch-relative readings at the trim extremes
        hold_until_drained(LATENCY_PAD);
        program_reg(REG_TRIM, 32'h0000_7FFF);
        send_sample(1'b1, SAMPLE_TOP[23:0]);
        send_sample(1'b1, SAMPLE_BOTTOM[23:0]);
        send_sample(1'b0, SAMPLE_TOP[23:0]);
        send_sample(1'b1, 24'd0);
        hold_until_drained(LATENCY_PAD);
        program_reg(REG_TRIM, 32'h0000_8000);
        send_sample(1'b1, SAMPLE_TOP[23:0]);
        send_sample(1'b1, SAMPLE_BOTTOM[23:0]);
        send_sample(1'b0, SAMPLE_BOTTOM[23:0]);
        send_sample(1'b1, 24'd0);

        // Random readings over several trims and the three idling regimes
        for (int p = 0; p < 6; p++) begin
            hold_until_drained(LATENCY_PAD);
            if (p == 2) begin
                tx_idle_pct = 75;
                rx_idle_pct = 6;
            end
            else if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0:       trim_val = 0;
                1:       trim_val = 32'h0000_7FFF;
                2:       trim_val = 32'h0000_8000;
                default: trim_val = $urandom;
            endcase
            program_reg(REG_TRIM, trim_val);
            program_reg(REG_THRESHOLD, $urandom);
            program_reg(REG_TIMEOUT, $urandom_range(1, 65535));
            check_reg(REG_TRIM);
            repeat (165) begin
                send_agl_item();
                if ($urandom_range(0, 63) == 0)
                    hold_until_drained(0);
            end
        end

        // Drain and report
        hold_until_drained(LATENCY_PAD);
        if (sb.errors == 0)
            $display("altitude_baseline_settle_unit_test: PASS");
        else
            $display("altitude_baseline_settle_unit_test: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
design/abs_pkg.sv
design/abs_cfg.sv
design/abs_ctrl.sv
design/abs_datapath.sv
design/altitude_baseline_settle_unit.sv
design/abs_checker.sv
bench/altitude_baseline_settle_unit_test.sv
